[hdl/gfw_pkg.sv]
// Shared types, constants and the 5x7 font table for the glyph framebuffer writer.
// Depends on nothing; every other file refers to it by scoped names.
package gfw_pkg;

    localparam int PANEL_WIDTH  = 128;
    localparam int PANEL_HEIGHT = 64;
    localparam int PAGES        = (PANEL_HEIGHT + 7) / 8;
    localparam int STORE_BYTES  = PANEL_WIDTH * PAGES;
    localparam int ADDR_W       = $clog2(STORE_BYTES);
    localparam int COL_W        = $clog2(PANEL_WIDTH);
    localparam int PAGE_W       = (PAGES > 1) ? $clog2(PAGES) : 1;

    localparam int FIRST_CODE  = 32;
    localparam int LAST_CODE   = 126;
    localparam int GLYPH_W     = 5;
    localparam int GLYPH_H     = 7;
    localparam int GLYPH_COUNT = LAST_CODE - FIRST_CODE + 1;
    localparam int MAX_SCALE   = 7;

    // Strip of one drawn column: up to 7 groups of up to 7 rows, plus a row offset of up to 7.
    localparam int STRIP_W     = 64;
    localparam int STRIP_PAGES = STRIP_W / 8;

    localparam logic [2:0] SCALE_RESET = 3'd2;

    typedef enum logic [2:0] {
        CMD_CLEAR   = 3'd0,
        CMD_PLOT    = 3'd1,
        CMD_UPRIGHT = 3'd2,
        CMD_ROTATED = 3'd3,
        CMD_READ    = 3'd4
    } cmd_t;

    typedef logic signed [9:0]   coord_t;
    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [STRIP_W-1:0]  strip_t;
    typedef logic [6:0]          glyph_idx_t;

    localparam coord_t PX_LIMIT = coord_t'(PANEL_WIDTH);
    localparam coord_t PG_LIMIT = coord_t'(PAGES);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;       // latch the input item
        logic sweep_write;  // write zero at the sweep address and advance it
        logic prep;         // build the strip of the current column, restart the page walk
        logic page_read;    // read the byte under the current page
        logic page_write;   // merge the strip into the byte just read
        logic page_next;    // advance to the next page
        logic col_next;     // advance to the next column
        logic byte_read;    // read the byte asked for by a read command
        logic result_load;  // move the result into the output register
    } gfw_ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sweep_last;
        logic page_hit;
        logic page_last;
        logic col_last;
        logic out_free;
    } gfw_status_t;

    // Font columns, first column in the top byte; bit 0 of a column is the top row.
    localparam logic [39:0] FONT_ROM [GLYPH_COUNT] = '{
        40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14, 40'h242a7f2a12,
        40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001c224100, 40'h0041221c00,
        40'h14083e0814, 40'h08083e0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
        40'h2010080402, 40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
        40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503, 40'h3649494936,
        40'h064949291e, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
        40'h0041221408, 40'h0201510906, 40'h324979413e, 40'h7e1111117e, 40'h7f49494936,
        40'h3e41414122, 40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
        40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
        40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e, 40'h7f09090906, 40'h3e4151215e,
        40'h7f09192946, 40'h4649494931, 40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f,
        40'h3f4038403f, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
        40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
        40'h2054545478, 40'h7f48444438, 40'h3844444420, 40'h384444487f, 40'h3854545418,
        40'h087e090102, 40'h0c5252523e, 40'h7f08040478, 40'h00447d4000, 40'h2040443d00,
        40'h7f10284400, 40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
        40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420, 40'h043f444020,
        40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c, 40'h4428102844, 40'h0c5050503c,
        40'h4464544c44, 40'h0008364100, 40'h00007f0000, 40'h0041360800, 40'h1008081008
    };

    // Repeat each of the seven group bits scale times, group 0 at bit 0.
    function automatic strip_t expand_strip(input logic [GLYPH_H-1:0] bits,
                                            input logic [2:0] scale);
        strip_t     res;
        logic [5:0] pos;
        res = '0;
        for (int g = 0; g < GLYPH_H; g++) begin
            for (int s = 0; s < MAX_SCALE; s++) begin
                pos = 6'(g) * 6'(scale) + 6'(s);
                if (3'(s) < scale) begin
                    res[pos] = bits[g];
                end
            end
        end
        return res;
    endfunction

endpackage

[hdl/gfw_ctrl.sv]
// Sequencer of the glyph framebuffer writer: clearing sweeps, column and page walks.
// Depends on gfw_pkg; drives gfw_datapath through gfw_ctrl_t and reads gfw_status_t.
module gfw_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_command,
    input  gfw_pkg::gfw_status_t status,
    output gfw_pkg::gfw_ctrl_t   ctrl
);

    typedef enum logic [7:0] {
        ST_INIT  = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_CLEAR = 8'b0000_0100,
        ST_PREP  = 8'b0000_1000,
        ST_PAGE  = 8'b0001_0000,
        ST_WRITE = 8'b0010_0000,
        ST_RDMEM = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    state_t walk_next;

    assign s_ready = (state_reg == ST_IDLE);

    // Where the page walk goes once the current page is dealt with.
    always_comb begin
        if (!status.page_last) begin
            walk_next = ST_PAGE;
        end else if (status.col_last) begin
            walk_next = ST_DONE;
        end else begin
            walk_next = ST_PREP;
        end
    end

    always_comb begin
        ctrl       = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                ctrl.sweep_write = 1'b1;
                if (status.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    ctrl.accept = 1'b1;
                    unique case (s_command) inside
                        gfw_pkg::CMD_CLEAR: begin
                            state_next = ST_CLEAR;
                        end
                        gfw_pkg::CMD_PLOT, gfw_pkg::CMD_UPRIGHT, gfw_pkg::CMD_ROTATED: begin
                            state_next = ST_PREP;
                        end
                        gfw_pkg::CMD_READ: begin
                            state_next = ST_RDMEM;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_CLEAR: begin
                ctrl.sweep_write = 1'b1;
                if (status.sweep_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_PREP: begin
                ctrl.prep  = 1'b1;
                state_next = ST_PAGE;
            end
            ST_PAGE: begin
                if (status.page_hit) begin
                    ctrl.page_read = 1'b1;
                    state_next     = ST_WRITE;
                end else begin
                    ctrl.page_next = !status.page_last;
                    ctrl.col_next  = status.page_last && !status.col_last;
                    state_next     = walk_next;
                end
            end
            ST_WRITE: begin
                ctrl.page_write = 1'b1;
                ctrl.page_next  = !status.page_last;
                ctrl.col_next   = status.page_last && !status.col_last;
                state_next      = walk_next;
            end
            ST_RDMEM: begin
                ctrl.byte_read = 1'b1;
                state_next     = ST_DONE;
            end
            ST_DONE: begin
                if (status.out_free) begin
                    ctrl.result_load = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[hdl/gfw_datapath.sv]
// Datapath of the glyph framebuffer writer: item registers, font lookup, strip
// builder, page addressing, the framebuffer memory and the output register. Uses gfw_pkg.
module gfw_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [2:0]           cfg_wr_data,
    input  logic [2:0]           s_command,
    input  logic signed [8:0]    s_x_pos,
    input  logic signed [8:0]    s_y_pos,
    input  logic [7:0]           s_char_code,
    input  logic                 s_pixel_on,
    input  logic [9:0]           s_byte_index,
    input  logic                 m_ready,
    output logic                 m_valid,
    output logic [7:0]           m_read_data,
    output logic                 m_was_read,
    input  gfw_pkg::gfw_ctrl_t   ctrl,
    output gfw_pkg::gfw_status_t status
);

    // Configuration and item registers
    logic [2:0]           scale_reg;
    logic [2:0]           cmd_reg;
    logic signed [8:0]    x_reg;
    logic signed [8:0]    y_reg;
    logic                 on_reg;
    gfw_pkg::addr_t       bidx_reg;
    logic                 bidx_ok_reg;
    logic [7:0]           glyph_reg [gfw_pkg::GLYPH_W];

    // Walk registers
    logic [2:0]           col_reg;
    logic [2:0]           page_reg;
    gfw_pkg::addr_t       sweep_reg;
    gfw_pkg::strip_t      strip_reg;
    gfw_pkg::strip_t      mask_reg;
    gfw_pkg::coord_t      px_reg;
    logic                 col_ok_reg;

    // Memory and output
    logic [7:0]           frame_store_reg [gfw_pkg::STORE_BYTES];
    logic [7:0]           rd_data_reg;
    logic                 m_valid_reg;
    logic [7:0]           m_read_data_reg;
    logic                 m_was_read_reg;

    // Combinational
    gfw_pkg::glyph_idx_t  glyph_idx;
    logic [39:0]          font_word;
    logic [6:0]           col_bits;
    logic [6:0]           col_ones;
    logic [2:0]           col_scale;
    logic [6:0]           rot_bits;
    gfw_pkg::coord_t      px_next;
    gfw_pkg::coord_t      page_calc;
    logic                 page_ok;
    logic [7:0]           page_mask;
    logic [7:0]           page_bits;
    logic [7:0]           merge_byte;
    gfw_pkg::addr_t       draw_addr;
    gfw_pkg::addr_t       mem_addr;
    logic                 mem_we;
    logic                 mem_re;
    logic [7:0]           mem_wdata;
    logic                 col_last;

    // Font lookup at accept: out-of-range codes fall back to space.
    always_comb begin
        if ((s_char_code >= 8'(gfw_pkg::FIRST_CODE)) && (s_char_code <= 8'(gfw_pkg::LAST_CODE)))
        begin
            glyph_idx = gfw_pkg::glyph_idx_t'(s_char_code - 8'(gfw_pkg::FIRST_CODE));
        end else begin
            glyph_idx = '0;
        end
        font_word = gfw_pkg::FONT_ROM[glyph_idx];
    end

    // Rotated: drawn column k takes bit (6 - k) of every font column.
    always_comb begin
        rot_bits = '0;
        for (int g = 0; g < gfw_pkg::GLYPH_W; g++) begin
            rot_bits[g] = glyph_reg[g][3'd6 - col_reg];
        end
    end

    always_comb begin
        case (cmd_reg)
            gfw_pkg::CMD_UPRIGHT: begin
                col_bits  = glyph_reg[col_reg][6:0];
                col_ones  = 7'h7f;
                col_scale = scale_reg;
                col_last  = (col_reg == 3'(gfw_pkg::GLYPH_W - 1));
            end
            gfw_pkg::CMD_ROTATED: begin
                col_bits  = rot_bits;
                col_ones  = 7'h1f;
                col_scale = scale_reg;
                col_last  = (col_reg == 3'(gfw_pkg::GLYPH_H - 1));
            end
            default: begin
                col_bits  = {6'd0, on_reg};
                col_ones  = 7'h01;
                col_scale = 3'd1;
                col_last  = 1'b1;
            end
        endcase
    end

    assign px_next = gfw_pkg::coord_t'(x_reg) + gfw_pkg::coord_t'({7'd0, col_reg});

    // Page under the walk: page of the strip origin plus the walk offset.
    always_comb begin
        page_calc  = gfw_pkg::coord_t'(y_reg >>> 3) + gfw_pkg::coord_t'({7'd0, page_reg});
        page_ok    = (page_calc >= 0) && (page_calc < gfw_pkg::PG_LIMIT);
        page_mask  = mask_reg[{page_reg, 3'b000} +: 8];
        page_bits  = strip_reg[{page_reg, 3'b000} +: 8];
        draw_addr  = gfw_pkg::addr_t'(page_calc[gfw_pkg::PAGE_W-1:0])
                     * gfw_pkg::addr_t'(gfw_pkg::PANEL_WIDTH)
                     + gfw_pkg::addr_t'(px_reg[gfw_pkg::COL_W-1:0]);
        if (cmd_reg == gfw_pkg::CMD_ROTATED) begin
            merge_byte = rd_data_reg | (page_bits & page_mask);
        end else begin
            merge_byte = (rd_data_reg & ~page_mask) | (page_bits & page_mask);
        end
    end

    always_comb begin
        mem_we    = ctrl.sweep_write || ctrl.page_write;
        mem_re    = ctrl.page_read || (ctrl.byte_read && bidx_ok_reg);
        mem_wdata = ctrl.sweep_write ? 8'd0 : merge_byte;
        if (ctrl.sweep_write) begin
            mem_addr = sweep_reg;
        end else if (ctrl.byte_read) begin
            mem_addr = bidx_reg;
        end else begin
            mem_addr = draw_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            frame_store_reg[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= frame_store_reg[mem_addr];
        end
    end

    // Item registers
    always_ff @(posedge aclk) begin
        if (ctrl.accept) begin
            cmd_reg     <= s_command;
            x_reg       <= s_x_pos;
            y_reg       <= s_y_pos;
            on_reg      <= s_pixel_on;
            bidx_reg    <= gfw_pkg::addr_t'(s_byte_index);
            bidx_ok_reg <= (int'(s_byte_index) < gfw_pkg::STORE_BYTES);
            for (int c = 0; c < gfw_pkg::GLYPH_W; c++) begin
                glyph_reg[c] <= font_word[39 - 8 * c -: 8];
            end
        end
    end

    // Column and page walk
    always_ff @(posedge aclk) begin
        if (ctrl.accept) begin
            col_reg <= '0;
        end else if (ctrl.col_next) begin
            col_reg <= col_reg + 3'd1;
        end
        if (ctrl.prep) begin
            page_reg   <= '0;
            strip_reg  <= gfw_pkg::expand_strip(col_bits, col_scale) << y_reg[2:0];
            mask_reg   <= gfw_pkg::expand_strip(col_ones, col_scale) << y_reg[2:0];
            px_reg     <= px_next;
            col_ok_reg <= (px_next >= 0) && (px_next < gfw_pkg::PX_LIMIT);
        end else if (ctrl.page_next) begin
            page_reg <= page_reg + 3'd1;
        end
    end

    // Control registers: sweep address, scale, output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg   <= '0;
            scale_reg   <= gfw_pkg::SCALE_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (ctrl.sweep_write) begin
                sweep_reg <= status.sweep_last ? '0 : sweep_reg + 1'b1;
            end
            if (cfg_wr_en) begin
                scale_reg <= cfg_wr_data;
            end
            if (ctrl.result_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.result_load) begin
            m_was_read_reg  <= (cmd_reg == gfw_pkg::CMD_READ);
            m_read_data_reg <= ((cmd_reg == gfw_pkg::CMD_READ) && bidx_ok_reg) ? rd_data_reg
                                                                                : 8'd0;
        end
    end

    assign status.sweep_last = (sweep_reg == gfw_pkg::addr_t'(gfw_pkg::STORE_BYTES - 1));
    assign status.page_hit   = col_ok_reg && page_ok && (page_mask != 8'd0);
    assign status.page_last  = (page_reg == 3'(gfw_pkg::STRIP_PAGES - 1));
    assign status.col_last   = col_last;
    assign status.out_free   = !m_valid_reg || m_ready;

    assign m_valid     = m_valid_reg;
    assign m_read_data = m_read_data_reg;
    assign m_was_read  = m_was_read_reg;

`ifndef NO_ASSERTIONS
    a_write_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.page_write |-> $past(ctrl.page_read))
        else $error("merge write without a preceding read");
    a_write_same_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.page_write |-> (mem_addr == $past(mem_addr)))
        else $error("merge write lands on a different byte than was read");
    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.result_load |-> (!m_valid_reg || m_ready))
        else $error("pending result overwritten");
    a_sweep_idle_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.accept |-> (sweep_reg == '0))
        else $error("item accepted while a sweep is under way");
`endif

endmodule

[hdl/glyph_framebuffer_writer.sv]
// From accept to m_valid: a clear zeroes every byte of the store; a plot or a glyph walks its columns;
// a read reads one byte; an unknown code goes straight to the result. Each column builds its strip,
// walks the strip pages with a read and a merge write per touched byte, and the result then comes out.
// Throughput: one item at a time; s_ready rises the cycle after the result is loaded, and the result
// is not loaded while the output register still holds an earlier one that waits on m_ready.
// Reset (aresetn, synchronous, active low): scale 2, then a clearing pass over every byte of the store
// during which s_ready stays low; configuration writes are still taken.
module glyph_framebuffer_writer (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration
    input  logic              cfg_wr_en,
    input  logic [2:0]        cfg_wr_data,
    // input item channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_command,
    input  logic signed [8:0] s_x_pos,
    input  logic signed [8:0] s_y_pos,
    input  logic [7:0]        s_char_code,
    input  logic              s_pixel_on,
    input  logic [9:0]        s_byte_index,
    // result item channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_read_data,
    output logic              m_was_read
);

    // Command and status between sequencer and datapath
    gfw_pkg::gfw_ctrl_t   ctrl;
    gfw_pkg::gfw_status_t status;

    // Sequencer: decode the accepted item, walk columns and pages, sweep the store
    gfw_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .status    (status),
        .ctrl      (ctrl)
    );

    // Datapath: hold the item, build each column strip, read-modify-write the store
    gfw_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_command    (s_command),
        .s_x_pos      (s_x_pos),
        .s_y_pos      (s_y_pos),
        .s_char_code  (s_char_code),
        .s_pixel_on   (s_pixel_on),
        .s_byte_index (s_byte_index),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_read_data  (m_read_data),
        .m_was_read   (m_was_read),
        .ctrl         (ctrl),
        .status       (status)
    );

endmodule
